>>> src/double_ended_queue_defines.svh
// Assertion macros for the double-ended queue checker.
// Each macro expands to one labeled concurrent assertion clocked by clk, gated by rst_n.
`ifndef DOUBLE_ENDED_QUEUE_DEFINES_SVH
`define DOUBLE_ENDED_QUEUE_DEFINES_SVH

// Same-cycle implication.
`define DEQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DEQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> src/deq_pkg.sv
// Shared constants for the double-ended queue: command and status codes,
// field widths and stream bus packing. No dependencies.
package deq_pkg;

    localparam int DEPTH_DEF = 64;

    localparam int OP_W      = 3;
    localparam int VAL_W     = 64;
    localparam int IDX_W     = 16;
    localparam int ST_W      = 2;
    localparam int CNT_OUT_W = 7;

    localparam int S_FIELDS_W = OP_W + VAL_W + IDX_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = ST_W + VAL_W + VAL_W + CNT_OUT_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int M_PAD_W    = M_TDATA_W - M_FIELDS_W;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd3;
    localparam logic [OP_W-1:0] OP_READ       = 3'd4;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd2;

endpackage

>>> src/deq_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module deq_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> src/deq_mod.sv
// Bit-serial remainder unit: dividend % divisor, one restoring step per cycle.
// Depends on deq_pkg for the index width.
module deq_mod #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [deq_pkg::IDX_W-1:0]     dividend,
    input  logic [$clog2(DEPTH+1)-1:0]    divisor,
    output logic [$clog2(DEPTH+1)-1:0]    rem,
    output logic                          done
);
    import deq_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = $clog2(IDX_W + 1);

    typedef logic [CW-1:0] cnt_t;
    typedef logic [CW:0]   trial_t;
    typedef logic [SW-1:0] step_t;

    step_t             step_reg, step_next;
    logic [IDX_W-1:0]  shf_reg, shf_next;
    cnt_t              rem_reg, rem_next;
    cnt_t              div_reg, div_next;
    logic              done_reg, done_next;
    trial_t            trial;

    always_comb
    begin
        step_next = step_reg;
        shf_next  = shf_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        done_next = 1'b0;
        trial     = {rem_reg, shf_reg[IDX_W-1]};
        if (start)
        begin
            step_next = step_t'(IDX_W);
            shf_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (step_reg != '0)
        begin
            // restoring step: shift in next dividend bit, subtract if it fits
            if (trial >= {1'b0, div_reg})
            begin
                rem_next = cnt_t'(trial - {1'b0, div_reg});
            end
            else
            begin
                rem_next = trial[CW-1:0];
            end
            shf_next  = {shf_reg[IDX_W-2:0], 1'b0};
            step_next = step_reg - step_t'(1);
            done_next = (step_reg == step_t'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shf_reg <= shf_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rem  = rem_reg;
    assign done = done_reg;

endmodule

>>> src/double_ended_queue.sv
// Top level of the double-ended queue: command sequencer, ring pointers, entry RAM
// and remainder unit. Depends on deq_pkg, deq_ram and deq_mod.
//
// Usage: one command enters on the s_* stream (push front/back, pop front/back,
// read by index) and exactly one result leaves on the m_* stream, carrying the
// status, the front entry, the value read and the entry count after the command.
// Commands are handled one at a time: s_tready is high only while the block is
// idle, and drops from the accepting edge until the result transfer completes.
// Pushes, pops and unused codes go from the accepting edge through the execute,
// front-address and front-data states before m_tvalid rises; with m_tready high the
// result transfers on the next edge. A read on a nonempty queue also passes through
// the remainder, read-address and read-data states: the index is reduced modulo
// the count by the bit-serial remainder unit, one bit of the 16-bit index per cycle,
// and the single read port of the entry RAM then fetches the read entry and the
// front entry in turn.
// The result is held in output registers while m_tready is low; no new command
// is taken until it is transferred.
// Reset clears the front position and the count, so the queue starts empty; the
// entry RAM is not cleared, since only entries written by a push are ever read.
module double_ended_queue #(
    parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // operation[2:0], value[66:3], index[82:67], zero pad above
    input  logic [deq_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // status[1:0], front_value[65:2], read_value[129:66], count[136:130], zero pad above
    output logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);
    import deq_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    typedef logic [PW-1:0] pos_t;
    typedef logic [PW:0]   pos_ext_t;
    typedef logic [CW-1:0] cnt_t;
    typedef logic [CW+CNT_OUT_W-1:0] cnt_wide_t;

    localparam pos_ext_t DEPTH_EXT = pos_ext_t'(DEPTH);
    localparam pos_t     LAST_POS  = pos_t'(DEPTH - 1);
    localparam cnt_t     DEPTH_CNT = cnt_t'(DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_RADDR = 3'd3;
    localparam logic [2:0] S_RDATA = 3'd4;
    localparam logic [2:0] S_FADDR = 3'd5;
    localparam logic [2:0] S_FDATA = 3'd6;
    localparam logic [2:0] S_OUT   = 3'd7;

    function automatic pos_t ring_slot(input pos_t base, input pos_t off);
        pos_ext_t sum;
        sum = {1'b0, base} + {1'b0, off};
        if (sum >= DEPTH_EXT)
        begin
            sum = sum - DEPTH_EXT;
        end
        return sum[PW-1:0];
    endfunction

    logic [2:0]       state_reg, state_next;
    pos_t             front_reg, front_next;
    cnt_t             count_reg, count_next;
    logic [OP_W-1:0]  op_reg, op_next;
    logic [VAL_W-1:0] val_reg, val_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ST_W-1:0]  status_reg, status_next;
    logic [VAL_W-1:0] fval_reg, fval_next;
    logic [VAL_W-1:0] rval_reg, rval_next;

    logic             mem_we;
    pos_t             mem_waddr;
    pos_t             mem_raddr;
    logic [VAL_W-1:0] mem_rdata;
    logic             mod_start;
    cnt_t             mod_rem;
    logic             mod_done;
    logic             is_empty;
    logic             is_full;
    pos_t             prev_front;
    cnt_wide_t        count_wide;

    assign is_empty   = (count_reg == '0);
    assign is_full    = (count_reg >= DEPTH_CNT);
    assign prev_front = (front_reg == '0) ? LAST_POS : front_reg - pos_t'(1);

    always_comb
    begin
        state_next  = state_reg;
        front_next  = front_reg;
        count_next  = count_reg;
        op_next     = op_reg;
        val_next    = val_reg;
        idx_next    = idx_reg;
        status_next = status_reg;
        fval_next   = fval_reg;
        rval_next   = rval_reg;
        mem_we      = 1'b0;
        mem_waddr   = front_reg;
        mem_raddr   = front_reg;
        mod_start   = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    op_next    = s_tdata[OP_W-1:0];
                    val_next   = s_tdata[OP_W+VAL_W-1:OP_W];
                    idx_next   = s_tdata[S_FIELDS_W-1:OP_W+VAL_W];
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                status_next = ST_OK;
                rval_next   = '0;
                state_next  = S_FADDR;
                unique case (op_reg)
                    OP_PUSH_FRONT:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            front_next = prev_front;
                            mem_we     = 1'b1;
                            mem_waddr  = prev_front;
                            count_next = count_reg + cnt_t'(1);
                        end
                    end
                    OP_PUSH_BACK:
                    begin
                        if (is_full)
                        begin
                            status_next = ST_FULL;
                        end
                        else
                        begin
                            mem_we     = 1'b1;
                            mem_waddr  = ring_slot(front_reg, count_reg[PW-1:0]);
                            count_next = count_reg + cnt_t'(1);
                        end
                    end
                    OP_POP_FRONT:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            front_next = ring_slot(front_reg, pos_t'(1));
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                    OP_POP_BACK:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            count_next = count_reg - cnt_t'(1);
                        end
                    end
                    OP_READ:
                    begin
                        if (is_empty)
                        begin
                            status_next = ST_EMPTY;
                        end
                        else
                        begin
                            mod_start  = 1'b1;
                            state_next = S_DIV;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_DIV:
            begin
                if (mod_done)
                begin
                    state_next = S_RADDR;
                end
            end
            S_RADDR:
            begin
                // remainder is below count, so it fits a ring position
                mem_raddr  = ring_slot(front_reg, mod_rem[PW-1:0]);
                state_next = S_RDATA;
            end
            S_RDATA:
            begin
                rval_next  = mem_rdata;
                state_next = S_FADDR;
            end
            S_FADDR:
            begin
                mem_raddr  = front_reg;
                state_next = S_FDATA;
            end
            S_FDATA:
            begin
                fval_next  = is_empty ? '0 : mem_rdata;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            front_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            front_reg <= front_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg     <= op_next;
        val_reg    <= val_next;
        idx_reg    <= idx_next;
        status_reg <= status_next;
        fval_reg   <= fval_next;
        rval_reg   <= rval_next;
    end

    deq_ram #(
        .WIDTH (VAL_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (val_reg),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    deq_mod #(
        .DEPTH (DEPTH)
    ) u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (idx_reg),
        .divisor  (count_reg),
        .rem      (mod_rem),
        .done     (mod_done)
    );

    assign count_wide = cnt_wide_t'(count_reg);
    assign s_tready   = (state_reg == S_IDLE);
    assign m_tvalid   = (state_reg == S_OUT);
    assign m_tdata    = {{M_PAD_W{1'b0}}, count_wide[CNT_OUT_W-1:0], rval_reg, fval_reg,
                         status_reg};

endmodule

>>> src/deq_chk.sv
// Port-level checker for the double-ended queue, bound to the top level.
// Depends on deq_pkg and the macros in double_ended_queue_defines.svh.
`include "double_ended_queue_defines.svh"

module deq_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [deq_pkg::M_TDATA_W-1:0] m_tdata
);
    import deq_pkg::*;

    logic             s_fire;
    logic             m_stall;
    logic             m_empty;
    logic             m_zero;
    logic [ST_W-1:0]  m_status;
    logic [VAL_W-1:0] m_front;
    logic [VAL_W-1:0] m_read;

    assign s_fire   = s_tvalid && s_tready;
    assign m_stall  = m_tvalid && !m_tready;
    assign m_status = m_tdata[ST_W-1:0];
    assign m_front  = m_tdata[ST_W+VAL_W-1:ST_W];
    assign m_read   = m_tdata[ST_W+2*VAL_W-1:ST_W+VAL_W];
    assign m_empty  = m_tvalid && (m_status == ST_EMPTY);
    assign m_zero   = (m_read == '0) && (m_front == '0);

    `DEQ_ASSERT_NOW(a_one_cmd, m_tvalid, !s_tready, "command taken while result pending")
    `DEQ_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_tready && !m_tvalid, "busy gap missing")
    `DEQ_ASSERT_NEXT(a_result_holds, m_stall, m_tvalid && $stable(m_tdata), "stall broke hold")
    `DEQ_ASSERT_NOW(a_empty_zero, m_empty, m_zero, "empty result carries data")

endmodule

bind double_ended_queue deq_chk u_deq_chk (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> sim/tb_double_ended_queue.sv
// Self-checking testbench for double_ended_queue: stream-driven commands, a local
// ring-buffer predictor and an in-order result scoreboard.
// Depends on deq_pkg and the double_ended_queue RTL.
module tb_double_ended_queue;
    import deq_pkg::*;

    localparam int QDEPTH = DEPTH_DEF;

    typedef struct packed {
        logic [ST_W-1:0]      status;
        logic [VAL_W-1:0]     front_value;
        logic [VAL_W-1:0]     read_value;
        logic [CNT_OUT_W-1:0] count;
    } deq_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;

    // predictor state
    logic [VAL_W-1:0] ring_mem [QDEPTH];
    int               head_pos;
    int               held;

    deq_result_t expected_results[$];
    deq_result_t got_result;
    deq_result_t want_result;

    int  error_count;
    int  cmds_sent;
    int  results_seen;
    int  full_drops;
    int  empty_hits;
    int  reads_done;
    int  rx_hold_req;
    bit  no_idle;

    double_ended_queue dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    initial
    begin
        #2000000;
        $display("Timeout with %0d results outstanding", expected_results.size());
        $display("FAILURE");
        $finish;
    end

    function automatic logic [VAL_W-1:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    // Applies one command to the local queue copy and returns the result it yields.
    function automatic deq_result_t apply_cmd(logic [OP_W-1:0] op, logic [VAL_W-1:0] value,
                                              logic [IDX_W-1:0] index);
        deq_result_t r;
        r.status     = ST_OK;
        r.read_value = '0;
        case (op)
            OP_PUSH_FRONT:
                if (held >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    head_pos           = (head_pos + QDEPTH - 1) % QDEPTH;
                    ring_mem[head_pos] = value;
                    held++;
                end
            OP_PUSH_BACK:
                if (held >= QDEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    ring_mem[(head_pos + held) % QDEPTH] = value;
                    held++;
                end
            OP_POP_FRONT:
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    head_pos = (head_pos + 1) % QDEPTH;
                    held--;
                end
            OP_POP_BACK:
                if (held == 0) r.status = ST_EMPTY;
                else held--;
            OP_READ:
                if (held == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    r.read_value = ring_mem[(head_pos + (int'(index) % held)) % QDEPTH];
                    reads_done++;
                end
            default: ;
        endcase
        if (r.status == ST_FULL) full_drops++;
        if (r.status == ST_EMPTY) empty_hits++;
        r.front_value = (held == 0) ? '0 : ring_mem[head_pos];
        r.count       = CNT_OUT_W'(held);
        return r;
    endfunction

    task automatic log_error(input string msg);
        error_count++;
        if (error_count <= 10) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    // Offer one command; returns once the transfer has happened.
    task automatic send_cmd(input logic [OP_W-1:0] op, input logic [VAL_W-1:0] value,
                            input logic [IDX_W-1:0] index);
        logic [S_TDATA_W-1:0] word;
        word = '0;
        word[OP_W-1:0]            = op;
        word[OP_W +: VAL_W]       = value;
        word[OP_W+VAL_W +: IDX_W] = index;
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        expected_results.push_back(apply_cmd(op, value, index));
        cmds_sent++;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(negedge clk);
    endtask

    // Result side: random ready, plus a long counted hold when requested.
    initial
    begin
        int hold_left;
        m_tready = 1'b0;
        forever begin
            @(negedge clk);
            if (rx_hold_req > 0) begin
                m_tready    <= 1'b0;
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
                while (hold_left > 0) begin
                    @(negedge clk);
                    hold_left--;
                end
            end else begin
                m_tready <= no_idle || ($urandom_range(0, 99) >= 38);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            got_result.status      = m_tdata[ST_W-1:0];
            got_result.front_value = m_tdata[ST_W +: VAL_W];
            got_result.read_value  = m_tdata[ST_W+VAL_W +: VAL_W];
            got_result.count       = m_tdata[ST_W+2*VAL_W +: CNT_OUT_W];
            results_seen++;
            if (expected_results.size() == 0) begin
                log_error($sformatf("result with nothing pending: st=%0d cnt=%0d",
                                    got_result.status, got_result.count));
            end else begin
                want_result = expected_results.pop_front();
                if (got_result !== want_result)
                    log_error($sformatf({"result %0d: exp st=%0d front=%h rd=%h cnt=%0d,",
                                         " got st=%0d front=%h rd=%h cnt=%0d"},
                                        results_seen, want_result.status,
                                        want_result.front_value, want_result.read_value,
                                        want_result.count, got_result.status,
                                        got_result.front_value, got_result.read_value,
                                        got_result.count));
            end
        end
    end

    task automatic test_empty_queue();
        send_cmd(OP_POP_FRONT, rand_word(), 16'h0000);
        send_cmd(OP_POP_BACK, rand_word(), 16'hFFFF);
        send_cmd(OP_READ, '0, 16'h0000);
        send_cmd(OP_READ, '1, 16'hFFFF);
        send_cmd(3'd5, rand_word(), 16'h1234);
        send_cmd(3'd6, '1, 16'hFFFF);
        send_cmd(3'd7, '0, 16'h0000);
        wait_drained();
    endtask

    task automatic test_basic_ops();
        send_cmd(OP_PUSH_FRONT, 64'h0, 16'hFFFF);
        send_cmd(OP_PUSH_BACK, 64'hFFFF_FFFF_FFFF_FFFF, 16'h0);
        send_cmd(OP_PUSH_FRONT, 64'h8000_0000_0000_0001, 16'h0);
        send_cmd(OP_PUSH_BACK, 64'h5555_AAAA_5555_AAAA, 16'h0);
        send_cmd(OP_READ, rand_word(), 16'h0000);
        send_cmd(OP_READ, rand_word(), 16'h0001);
        send_cmd(OP_READ, rand_word(), 16'hFFFF);
        send_cmd(OP_READ, rand_word(), 16'h8000);
        send_cmd(3'd5, rand_word(), 16'($urandom()));
        send_cmd(3'd6, rand_word(), 16'($urandom()));
        send_cmd(3'd7, rand_word(), 16'($urandom()));
        send_cmd(OP_POP_FRONT, rand_word(), 16'h0);
        send_cmd(OP_POP_BACK, rand_word(), 16'h0);
        send_cmd(OP_POP_FRONT, rand_word(), 16'h0);
        send_cmd(OP_POP_FRONT, rand_word(), 16'h0);
        send_cmd(OP_POP_BACK, rand_word(), 16'h0);
        wait_drained();
    endtask

    // Full-rate stretch: fill to capacity, hit the full case, read across the wrap, drain.
    task automatic test_fill_and_drain();
        no_idle = 1'b1;
        while (held != 0) send_cmd(OP_POP_BACK, '0, '0);
        for (int i = 0; i < QDEPTH; i++)
            send_cmd((i % 2) ? OP_PUSH_BACK : OP_PUSH_FRONT, rand_word(), '0);
        send_cmd(OP_PUSH_FRONT, rand_word(), '0);
        send_cmd(OP_PUSH_BACK, '1, '0);
        send_cmd(OP_READ, '0, 16'(QDEPTH - 1));
        send_cmd(OP_READ, '0, 16'(QDEPTH));
        send_cmd(OP_READ, '0, 16'hFFFF);
        for (int i = 0; i < 4; i++) send_cmd(OP_READ, '0, 16'($urandom()));
        for (int i = 0; i < QDEPTH; i++)
            send_cmd((i % 2) ? OP_POP_FRONT : OP_POP_BACK, '0, '0);
        send_cmd(OP_POP_FRONT, '0, '0);
        wait_drained();
        no_idle = 1'b0;
    endtask

    // Long receiver hold while further commands are offered but not taken, then a full pause.
    task automatic test_output_stall();
        rx_hold_req = 400;
        for (int i = 0; i < 20; i++)
            send_cmd(3'($urandom_range(0, 4)), rand_word(), 16'($urandom()));
        wait_drained();
    endtask

    task automatic test_random_traffic(input int n_items);
        int               sent;
        int               burst_len;
        int               push_share;
        int               r;
        logic [OP_W-1:0]  op;
        logic [IDX_W-1:0] index;
        sent = 0;
        while (sent < n_items) begin
            burst_len = $urandom_range(20, 120);
            case ($urandom_range(0, 2))
                0:       push_share = 68;
                1:       push_share = 40;
                default: push_share = 12;
            endcase
            for (int i = 0; i < burst_len && sent < n_items; i++) begin
                r = $urandom_range(0, 99);
                if (r < 5)
                    op = 3'($urandom_range(5, 7));
                else if (r < 5 + push_share)
                    op = $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
                else if (r < 85)
                    op = $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
                else
                    op = OP_READ;
                if ($urandom_range(0, 1)) index = 16'($urandom());
                else index = 16'($urandom_range(0, held + 1));
                send_cmd(op, rand_word(), index);
                sent++;
            end
            if ($urandom_range(0, 9) == 0) wait_drained();
        end
        wait_drained();
    endtask

    initial
    begin
        int guard;
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        head_pos    = 0;
        held        = 0;
        error_count = 0;
        cmds_sent   = 0;
        results_seen = 0;
        full_drops  = 0;
        empty_hits  = 0;
        reads_done  = 0;
        rx_hold_req = 0;
        no_idle     = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;

        test_empty_queue();
        test_basic_ops();
        test_fill_and_drain();
        test_output_stall();
        test_random_traffic(1800);

        guard = 0;
        while (expected_results.size() != 0 && guard < 10000) begin
            @(posedge clk);
            guard++;
        end
        repeat (40) @(posedge clk);
        if (expected_results.size() != 0)
            log_error($sformatf("%0d results never arrived", expected_results.size()));

        $display("Ran %0d commands, checked %0d results, %0d errors", cmds_sent,
                 results_seen, error_count);
        $display("Covered %0d push drops on full, %0d ops on empty, %0d indexed reads",
                 full_drops, empty_hits, reads_done);
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

>>> sim.f
+incdir+src
src/deq_pkg.sv
src/deq_ram.sv
src/deq_mod.sv
src/double_ended_queue.sv
src/deq_chk.sv
sim/tb_double_ended_queue.sv
